>>> src/ps2sc_pkg.sv
`timescale 1ns / 1ps

package ps2sc_pkg;

    // Queue depth default
    localparam int FIFO_DEPTH_DEF = 16;

    // Item codes
    localparam logic MODE_SCAN = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Prefix bytes
    localparam logic [7:0] PFX_BREAK = 8'hF0;
    localparam logic [7:0] PFX_EXT   = 8'hE0;
    localparam logic [7:0] EXT_KP_SLASH_BYTE = 8'h4A;

    // Key codes
    localparam logic [5:0] KEY_NONE     = 6'd0;
    localparam logic [5:0] KEY_LSHIFT   = 6'd42;
    localparam logic [5:0] KEY_RSHIFT   = 6'd43;
    localparam logic [5:0] KEY_KP_SLASH = 6'd46;

    typedef struct packed {
        logic       mode;
        logic [7:0] scan_byte;
    } cmd_t;

    typedef struct packed {
        logic [5:0] key_code;
        logic       pressed;
        logic       shift_down;
        logic       empty_res;
    } rsp_t;

    // One stored event, 8 bits
    typedef struct packed {
        logic       shift_down;
        logic       pressed;
        logic [5:0] key_code;
    } event_t;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] third;
    } pend_t;

    // Decoder result toward the queue control
    typedef struct packed {
        logic       ev_valid;
        event_t     ev;
        pend_t      pend_next;
        logic       shift_next;
    } dec_t;

    function automatic logic [5:0] look_plain(input logic [7:0] b);
        logic [5:0] k;
        case (b)
            8'h01: k = 6'd9;
            8'h02: k = 6'd5;
            8'h04: k = 6'd3;
            8'h05: k = 6'd1;
            8'h06: k = 6'd2;
            8'h07: k = 6'd12;
            8'h09: k = 6'd10;
            8'h0A: k = 6'd8;
            8'h0B: k = 6'd6;
            8'h0C: k = 6'd4;
            8'h12: k = 6'd42;
            8'h15: k = 6'd29;
            8'h1A: k = 6'd38;
            8'h1B: k = 6'd31;
            8'h1C: k = 6'd13;
            8'h1D: k = 6'd35;
            8'h21: k = 6'd15;
            8'h22: k = 6'd36;
            8'h23: k = 6'd16;
            8'h24: k = 6'd17;
            8'h29: k = 6'd39;
            8'h2A: k = 6'd34;
            8'h2B: k = 6'd18;
            8'h2C: k = 6'd32;
            8'h2D: k = 6'd30;
            8'h31: k = 6'd26;
            8'h32: k = 6'd14;
            8'h33: k = 6'd20;
            8'h34: k = 6'd19;
            8'h35: k = 6'd37;
            8'h3A: k = 6'd25;
            8'h3B: k = 6'd22;
            8'h3C: k = 6'd33;
            8'h42: k = 6'd23;
            8'h43: k = 6'd21;
            8'h44: k = 6'd27;
            8'h4B: k = 6'd24;
            8'h4D: k = 6'd28;
            8'h59: k = 6'd43;
            8'h5A: k = 6'd40;
            8'h66: k = 6'd41;
            8'h71: k = 6'd44;
            8'h7B: k = 6'd45;
            default: k = KEY_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] look_ext(input logic [7:0] b);
        return (b == EXT_KP_SLASH_BYTE) ? KEY_KP_SLASH : KEY_NONE;
    endfunction

endpackage

>>> src/ps2sc_decode.sv
`timescale 1ns / 1ps

module ps2sc_decode (
    input  ps2sc_pkg::pend_t pend,
    input  logic             shift_held,
    input  logic [7:0]       scan_byte,
    output ps2sc_pkg::dec_t  dec
);
    import ps2sc_pkg::*;

    pend_t      filled;
    logic [5:0] make_key;
    logic [5:0] brk_key;
    logic       is_make;
    logic       is_brk;
    logic [5:0] key;

    // Drop the byte into the first empty slot; restart when all are full
    always_comb
    begin
        filled = pend;
        if (pend.first == 8'd0)
        begin
            filled.first = scan_byte;
        end
        else if (pend.second == 8'd0)
        begin
            filled.second = scan_byte;
        end
        else if (pend.third == 8'd0)
        begin
            filled.third = scan_byte;
        end
        else
        begin
            filled = '{first: scan_byte, second: 8'd0, third: 8'd0};
        end
    end

    always_comb
    begin
        make_key = look_plain(filled.first);
        if (make_key == KEY_NONE && filled.second != 8'd0)
        begin
            make_key = look_ext(filled.second);
        end
        if (filled.first == PFX_BREAK)
        begin
            brk_key = look_plain(filled.second);
        end
        else if (filled.first == PFX_EXT && filled.second == PFX_BREAK)
        begin
            brk_key = look_ext(filled.third);
        end
        else
        begin
            brk_key = KEY_NONE;
        end
    end

    assign is_make = (make_key != KEY_NONE);
    assign is_brk  = !is_make && (brk_key != KEY_NONE);
    assign key     = is_make ? make_key : brk_key;

    always_comb
    begin
        dec.ev_valid      = is_make || is_brk;
        dec.ev.key_code   = key;
        dec.ev.pressed    = is_make;
        dec.ev.shift_down = shift_held;
        dec.pend_next     = (is_make || is_brk) ? '0 : filled;
        dec.shift_next    = shift_held;
        if ((is_make || is_brk) && (key == KEY_LSHIFT || key == KEY_RSHIFT))
        begin
            dec.shift_next = is_make;
        end
    end

endmodule

>>> src/ps2_set2_scancode_decoder.sv
`timescale 1ns / 1ps

// Channel | Signals                  | Direction | Transfer when
// --------+--------------------------+-----------+---------------------------
// cmd     | cmd_valid, cmd_stall, cmd | in       | cmd_valid && !cmd_stall
// rsp     | rsp_valid, rsp_stall, rsp | out      | rsp_valid && !rsp_stall
//
// One command per cycle is taken while nothing stalls. A command is held in the
// input register, where it is decoded and the event queue updated; a read
// command's result then loads into the output register, which doubles as the
// queue memory's read register, and transfers from there. Reset clears the
// pending bytes, the shift flag, the queue pointers and both valid flags; queue
// contents are not cleared. While a result in the output register is stalled, a
// read command waits in the input register (cmd_stall rises); scan commands keep
// flowing unless a read waits ahead of them.

module ps2_set2_scancode_decoder #(
    parameter int FIFO_DEPTH = ps2sc_pkg::FIFO_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  ps2sc_pkg::cmd_t cmd,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output ps2sc_pkg::rsp_t rsp
);
    import ps2sc_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    // Input register
    logic       in_valid_reg;
    cmd_t       in_data_reg;

    // Decoder state
    pend_t      pend_reg;
    logic       shift_reg;
    dec_t       dec;

    // Event queue
    event_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    // Output register
    logic       out_valid_reg;
    logic       empty_reg;
    event_t     rd_data_reg;

    logic       out_free;
    logic       is_read;
    logic       advance;
    logic       do_write;
    logic       do_pop;

    ps2sc_decode u_decode (
        .pend       (pend_reg),
        .shift_held (shift_reg),
        .scan_byte  (in_data_reg.scan_byte),
        .dec        (dec)
    );

    // The output slot frees when empty or being taken this cycle
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign is_read   = (in_data_reg.mode == MODE_READ);
    assign advance   = in_valid_reg && (!is_read || out_free);
    assign cmd_stall = in_valid_reg && !advance;

    assign do_write = advance && !is_read && dec.ev_valid && (count_reg != CNT_FULL);
    assign do_pop   = advance && is_read && (count_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!cmd_stall)
        begin
            in_valid_reg <= cmd_valid;
        end
    end

    // Payload holds while stalled
    always_ff @(posedge clk)
    begin
        if (!cmd_stall && cmd_valid)
        begin
            in_data_reg <= cmd;
        end
    end

    // Advance pending bytes and shift flag on each scan command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            shift_reg <= 1'b0;
        end
        else if (advance && !is_read)
        begin
            pend_reg  <= dec.pend_next;
            shift_reg <= dec.shift_next;
        end
    end

    // Queue pointers and fill count; a full queue drops the new event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_write)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
                count_reg  <= count_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
                count_reg  <= count_reg - 1'b1;
            end
        end
    end

    // Queue memory with registered read
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[wr_ptr_reg] <= dec.ev;
        end
        if (do_pop)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            empty_reg     <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && is_read;
            if (advance && is_read)
            begin
                empty_reg <= (count_reg == '0);
            end
        end
    end

    assign rsp_valid = out_valid_reg;

    // Zero the event fields on an empty read
    always_comb
    begin
        rsp.empty_res  = empty_reg;
        rsp.key_code   = empty_reg ? KEY_NONE : rd_data_reg.key_code;
        rsp.pressed    = !empty_reg && rd_data_reg.pressed;
        rsp.shift_down = !empty_reg && rd_data_reg.shift_down;
    end

endmodule

>>> test/tb_ps2_set2_scancode_decoder.sv
`timescale 1ns / 1ps

module tb_ps2_set2_scancode_decoder;

    import ps2sc_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int EVENT_DEPTH = FIFO_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_GAP   = 4;     // settling margin after the last result
    localparam int RANDOM_PART = 237;   // random items per idling phase
    localparam int HOLD_CYCLES = 150;

    localparam logic [7:0] LSHIFT_BYTE = 8'h12;
    localparam logic [7:0] RSHIFT_BYTE = 8'h59;
    localparam logic [7:0] A_BYTE      = 8'h1C;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Shadow of the decoder state, advanced at every command transfer
    logic [7:0] slot_a = 8'h00;
    logic [7:0] slot_b = 8'h00;
    logic [7:0] slot_c = 8'h00;
    logic       shift_state = 1'b0;
    event_t     queued_keys[$];
    rsp_t       read_replies_due[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asks     = 0;
    int hold_taken    = 0;
    int hold_left     = 0;
    int cycles        = 0;
    int mismatches    = 0;
    int scans_sent    = 0;
    int reads_sent    = 0;
    int keys_seen     = 0;
    int empties_seen  = 0;
    int keys_dropped  = 0;

    ps2_set2_scancode_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog: end the run if the traffic never drains
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycles, read_replies_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Set-2 single-byte codes; anything at 80 and above, or unlisted, is no key.
    // Byte 02 gives F5 and byte 03 gives nothing.
    function automatic logic [5:0] key_of_byte(input logic [7:0] b);
        logic [5:0] k;
        k = KEY_NONE;
        case (b)
            // function keys
            8'h05: k = 6'd1;   8'h06: k = 6'd2;   8'h04: k = 6'd3;   8'h0C: k = 6'd4;
            8'h02: k = 6'd5;   8'h0B: k = 6'd6;   8'h0A: k = 6'd8;   8'h01: k = 6'd9;
            8'h09: k = 6'd10;  8'h07: k = 6'd12;
            // letters
            8'h1C: k = 6'd13;  8'h32: k = 6'd14;  8'h21: k = 6'd15;  8'h23: k = 6'd16;
            8'h24: k = 6'd17;  8'h2B: k = 6'd18;  8'h34: k = 6'd19;  8'h33: k = 6'd20;
            8'h43: k = 6'd21;  8'h3B: k = 6'd22;  8'h42: k = 6'd23;  8'h4B: k = 6'd24;
            8'h3A: k = 6'd25;  8'h31: k = 6'd26;  8'h44: k = 6'd27;  8'h4D: k = 6'd28;
            8'h15: k = 6'd29;  8'h2D: k = 6'd30;  8'h1B: k = 6'd31;  8'h2C: k = 6'd32;
            8'h3C: k = 6'd33;  8'h2A: k = 6'd34;  8'h1D: k = 6'd35;  8'h22: k = 6'd36;
            8'h35: k = 6'd37;  8'h1A: k = 6'd38;
            // space, enter, backspace, shifts, keypad
            8'h29: k = 6'd39;  8'h5A: k = 6'd40;  8'h66: k = 6'd41;
            8'h12: k = KEY_LSHIFT;  8'h59: k = KEY_RSHIFT;
            8'h71: k = 6'd44;  8'h7B: k = 6'd45;
            default: k = KEY_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] ext_key_of_byte(input logic [7:0] b);
        return (b == EXT_KP_SLASH_BYTE) ? KEY_KP_SLASH : KEY_NONE;
    endfunction

    // Queue one key event; a full queue drops it, but the slots and the
    // shift flag move on regardless. A shift key carries the old flag.
    function automatic void log_key(input logic [5:0] k, input logic down);
        event_t ev;
        ev.key_code   = k;
        ev.pressed    = down;
        ev.shift_down = shift_state;
        if (queued_keys.size() < EVENT_DEPTH)
            queued_keys.push_back(ev);
        else
            keys_dropped++;
        slot_a = 8'h00;
        slot_b = 8'h00;
        slot_c = 8'h00;
        if (k == KEY_LSHIFT || k == KEY_RSHIFT)
            shift_state = down;
    endfunction

    function automatic void decode_scan(input logic [7:0] b);
        logic [5:0] k;
        // Fill the first empty slot; a fourth byte restarts the sequence
        if (slot_a == 8'h00)
            slot_a = b;
        else if (slot_b == 8'h00)
            slot_b = b;
        else if (slot_c == 8'h00)
            slot_c = b;
        else
        begin
            slot_a = b;
            slot_b = 8'h00;
            slot_c = 8'h00;
        end
        // Make lookup: plain on the first slot, else extended on the second
        k = key_of_byte(slot_a);
        if (k == KEY_NONE && slot_b != 8'h00)
            k = ext_key_of_byte(slot_b);
        if (k != KEY_NONE)
        begin
            log_key(k, 1'b1);
            return;
        end
        // Break lookup: F0 x, or E0 F0 x
        if (slot_a == PFX_BREAK)
            k = key_of_byte(slot_b);
        else if (slot_a == PFX_EXT && slot_b == PFX_BREAK)
            k = ext_key_of_byte(slot_c);
        if (k != KEY_NONE)
            log_key(k, 1'b0);
    endfunction

    function automatic void decode_read();
        rsp_t r;
        event_t ev;
        r = '0;
        if (queued_keys.size() == 0)
            r.empty_res = 1'b1;
        else
        begin
            ev = queued_keys.pop_front();
            r.key_code   = ev.key_code;
            r.pressed    = ev.pressed;
            r.shift_down = ev.shift_down;
        end
        read_replies_due.push_back(r);
    endfunction

    // Offer one command, hold it until the transfer, then advance the shadow.
    // Valid stays high on return so back-to-back commands need no re-raise.
    task automatic send_cmd(input logic m, input logic [7:0] b);
        cmd_t c;
        c.mode      = m;
        c.scan_byte = b;
        if ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do @(posedge clk); while (cmd_stall);
        if (m == MODE_READ)
        begin
            reads_sent++;
            decode_read();
        end
        else
        begin
            scans_sent++;
            decode_scan(b);
        end
    endtask

    task automatic send_scan(input logic [7:0] b);
        send_cmd(MODE_SCAN, b);
    endtask

    // Read with a random, ignored byte attached
    task automatic send_read();
        send_cmd(MODE_READ, 8'($urandom_range(255)));
    endtask

    // Pop every queued key, then one more read that must report empty
    task automatic read_all_events();
        while (queued_keys.size() != 0)
            send_read();
        send_read();
    endtask

    task automatic pause_until_drained();
        cmd_valid <= 1'b0;
        while (read_replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    function automatic logic [7:0] any_key_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(127)); while (key_of_byte(b) == KEY_NONE);
        return b;
    endfunction

    task automatic test_basic_keys();
        send_read();                    // empty queue
        send_scan(A_BYTE);              // A down
        send_scan(PFX_BREAK);
        send_scan(A_BYTE);              // A up
        send_scan(LSHIFT_BYTE);         // shift event carries the old flag
        send_scan(A_BYTE);              // A down with shift held
        send_scan(PFX_BREAK);
        send_scan(LSHIFT_BYTE);
        send_scan(RSHIFT_BYTE);
        send_scan(PFX_BREAK);
        send_scan(RSHIFT_BYTE);
        read_all_events();
    endtask

    task automatic test_prefixes();
        send_scan(PFX_EXT);
        send_read();                    // read in the middle must not disturb the slots
        send_scan(EXT_KP_SLASH_BYTE);   // keypad slash down
        send_scan(PFX_EXT);
        send_scan(PFX_BREAK);
        send_scan(EXT_KP_SLASH_BYTE);   // keypad slash up
        send_scan(PFX_EXT);
        send_scan(8'h00);               // zero byte leaves the slot empty
        send_scan(EXT_KP_SLASH_BYTE);
        send_scan(PFX_BREAK);
        send_scan(EXT_KP_SLASH_BYTE);   // break prefix still hits the extended make path
        read_all_events();
    endtask

    task automatic test_table_quirks();
        send_scan(8'h02);               // decodes as F5
        send_scan(8'h03);               // no key
        send_scan(8'hFF);
        send_scan(8'h80);               // all three slots now full, no match
        send_scan(8'h07);               // fourth byte restarts: F12
        send_scan(8'h83);               // F7 position, no key
        send_scan(8'h7F);
        send_scan(8'h00);
        send_scan(8'h71);
        read_all_events();
    endtask

    task automatic test_queue_overflow();
        read_all_events();
        send_scan(LSHIFT_BYTE);
        repeat (EVENT_DEPTH + 1) send_scan(any_key_byte());
        send_scan(PFX_BREAK);
        send_scan(LSHIFT_BYTE);         // dropped, but the shift flag still clears
        send_scan(A_BYTE);
        read_all_events();
    endtask

    // Mostly well-formed strokes with random keys, plus reads and raw noise
    task automatic random_stroke();
        int pick;
        logic [7:0] k;
        pick = $urandom_range(99);
        k = any_key_byte();
        if ($urandom_range(3) == 0)
            k = $urandom_range(1) ? LSHIFT_BYTE : RSHIFT_BYTE;
        if (pick < 40)
            send_read();
        else if (pick < 52)
            send_scan(8'($urandom_range(255)));
        else if (pick < 60)
        begin
            send_scan(PFX_EXT);
            if ($urandom_range(1))
                send_scan(PFX_BREAK);
            send_scan(EXT_KP_SLASH_BYTE);
        end
        else if (pick < 80)
            send_scan(k);
        else
        begin
            send_scan(PFX_BREAK);
            send_scan(k);
        end
    endtask

    task automatic test_random_traffic(input int n);
        int start;
        start = scans_sent + reads_sent;
        while (scans_sent + reads_sent - start < n)
            random_stroke();
    endtask

    // Hold the output for a long stretch while commands keep coming, so the
    // result register fills and read commands back up into the input
    task automatic test_output_backpressure();
        hold_asks <= hold_asks + 1;
        repeat (40) random_stroke();
        pause_until_drained();
    endtask

    // Receiver: random stall, or a forced hold while hold_left counts down
    always @(posedge clk)
    begin
        if (hold_asks != hold_taken)
        begin
            hold_taken <= hold_asks;
            hold_left  <= HOLD_CYCLES - 1;
            rsp_stall  <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic report_mismatch(input string what, input rsp_t want, input rsp_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected key %0d pressed %0b shift %0b empty %0b,",
                     $realtime, what, want.key_code, want.pressed, want.shift_down,
                     want.empty_res,
                     " got key %0d pressed %0b shift %0b empty %0b",
                     got.key_code, got.pressed, got.shift_down, got.empty_res);
    endtask

    // Check every result transfer against the oldest outstanding read
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (read_replies_due.size() == 0)
                report_mismatch("unexpected result", '0, rsp);
            else
            begin
                want = read_replies_due.pop_front();
                if (rsp.key_code !== want.key_code || rsp.pressed !== want.pressed ||
                    rsp.shift_down !== want.shift_down || rsp.empty_res !== want.empty_res)
                    report_mismatch("result mismatch", want, rsp);
                if (want.empty_res)
                    empties_seen++;
                else
                    keys_seen++;
            end
        end
    end

    initial
    begin
        send_idle_pct <= 24;
        recv_idle_pct <= 51;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_keys();
        test_prefixes();
        test_table_quirks();
        test_queue_overflow();
        test_output_backpressure();
        test_random_traffic(RANDOM_PART);

        pause_until_drained();
        send_idle_pct <= 51;
        recv_idle_pct <= 24;
        test_random_traffic(RANDOM_PART);

        pause_until_drained();
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        test_random_traffic(RANDOM_PART);

        pause_until_drained();

        $display("covered %0d scan bytes and %0d reads: %0d key events, %0d empty reads",
                 scans_sent, reads_sent, keys_seen, empties_seen);
        $display("%0d events dropped on a full queue, %0d mismatches", keys_dropped, mismatches);
        if (mismatches == 0 && read_replies_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
